// ----- hdl/ordered_list_buffer_defines.svh -----
// Assertion macros used by the list buffer RTL.
`ifndef ORDERED_LIST_BUFFER_DEFINES_SVH
`define ORDERED_LIST_BUFFER_DEFINES_SVH

`ifndef SYNTHESIS

// Checked only while reset is released.
`define OLB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ordered_list_buffer: assertion failed");

// Checked at every edge, reset included.
`define OLB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ordered_list_buffer: assertion failed");

`else

`define OLB_ASSERT(lbl, clk, rstn, prop)
`define OLB_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- hdl/olb_pkg.sv -----
package olb_pkg;

  localparam int Capacity = 16;
  localparam int DataW    = 32;
  localparam int PosW     = 5;
  localparam int IdxW     = 4;
  localparam int CntW     = 5;
  localparam int TouchW   = 5;

  typedef enum logic [2:0] {
    OpInsert = 3'd0,
    OpAppend = 3'd1,
    OpErase  = 3'd2,
    OpRead   = 3'd3,
    OpWrite  = 3'd4,
    OpFind   = 3'd5,
    OpRemove = 3'd6,
    OpClear  = 3'd7
  } olb_op_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StRange = 2'd1,
    StFull  = 2'd2
  } olb_status_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic            ins_en;
    logic            del_en;
    logic            rem_en;
    logic            wr_en;
    logic            rd_en;
    logic [PosW-1:0] pos;
    logic [CntW-1:0] cnt;
    logic [DataW-1:0] value;
  } olb_cmd_t;

endpackage

// ----- hdl/ordered_list_buffer.sv -----
// Ordered list of up to 16 signed words held in a chain of cells. Every beat
// (insert, append, erase, read, write, find, remove, clear) is applied to the
// whole chain: all cells shift, load or compare in parallel in the cycle the beat
// is accepted. The result appears in an output register on the next cycle.
// While that result waits under an output stall, the input stalls with it.
// One beat per cycle is sustained as long as results are taken when they
// appear. The first-match search ripples through the cells in the same cycle.
// Entries above the current length hold stale data and are never reported.
module ordered_list_buffer
  import olb_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [2:0]              op_i,
  input  logic signed [DataW-1:0] value_i,
  input  logic [PosW-1:0]         position_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] read_value_o,
  output logic                    found_o,
  output logic [IdxW-1:0]         found_index_o,
  output logic [1:0]              status_o,
  output logic [CntW-1:0]         length_o,
  output logic [TouchW-1:0]       touched_o
);

`include "ordered_list_buffer_defines.svh"

  logic            accept;
  olb_op_e         op;
  olb_cmd_t        cmd;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PosW-1:0] pos_eff;
  logic            ins, del, rem, wr, rd;
  olb_status_e     status;
  logic            found;
  logic [TouchW-1:0] touched;

  logic [DataW-1:0] data  [Capacity];
  logic             first [Capacity];
  logic [Capacity-1:0] first_vec;
  logic             seen  [Capacity+1];
  logic [DataW-1:0] rdc   [Capacity+1];
  logic [IdxW-1:0]  fidx;
  logic             any_match;

  logic                    out_valid_q;
  logic [DataW-1:0]        read_value_q;
  logic                    found_q;
  logic [IdxW-1:0]         found_index_q;
  logic [1:0]              status_q;
  logic [CntW-1:0]         length_q;
  logic [TouchW-1:0]       touched_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign op         = olb_op_e'(op_i);

  always_comb begin
    ins     = 1'b0;
    del     = 1'b0;
    rem     = 1'b0;
    wr      = 1'b0;
    rd      = 1'b0;
    status  = StOk;
    found   = 1'b0;
    touched = '0;
    cnt_d   = cnt_q;
    pos_eff = (op == OpAppend) ? PosW'(cnt_q) : position_i;
    case (op)
      OpInsert, OpAppend: begin
        if (pos_eff > PosW'(cnt_q)) begin
          status = StRange;
        end else if (cnt_q >= CntW'(Capacity)) begin
          status = StFull;
        end else begin
          ins     = 1'b1;
          touched = TouchW'(cnt_q - CntW'(pos_eff) + CntW'(1));
          cnt_d   = cnt_q + CntW'(1);
        end
      end
      OpErase: begin
        if (pos_eff >= PosW'(cnt_q)) begin
          status = StRange;
        end else begin
          del     = 1'b1;
          touched = TouchW'(cnt_q - CntW'(pos_eff));
          cnt_d   = cnt_q - CntW'(1);
        end
      end
      OpRead: begin
        if (pos_eff >= PosW'(cnt_q)) begin
          status = StRange;
        end else begin
          rd = 1'b1;
        end
      end
      OpWrite: begin
        if (pos_eff >= PosW'(cnt_q)) begin
          status = StRange;
        end else begin
          wr = 1'b1;
        end
      end
      OpFind: begin
        if (any_match) begin
          found   = 1'b1;
          touched = TouchW'(fidx) + TouchW'(1);
        end else begin
          touched = TouchW'(cnt_q);
        end
      end
      OpRemove: begin
        if (any_match) begin
          found   = 1'b1;
          rem     = 1'b1;
          touched = TouchW'(cnt_q - CntW'(fidx));
          cnt_d   = cnt_q - CntW'(1);
        end else begin
          touched = TouchW'(cnt_q);
        end
      end
      OpClear: begin
        cnt_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd.ins_en = ins && accept;
    cmd.del_en = del && accept;
    cmd.rem_en = rem && accept;
    cmd.wr_en  = wr && accept;
    cmd.rd_en  = rd;
    cmd.pos    = pos_eff;
    cmd.cnt    = cnt_q;
    cmd.value  = value_i;
  end

  assign seen[0] = 1'b0;
  assign rdc[0]  = '0;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [DataW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = data[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign right = data[i];
    end else begin : g_inner
      assign right = data[i+1];
    end

    olb_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .idx_i   (IdxW'(i)),
      .left_i  (left),
      .right_i (right),
      .seen_i  (seen[i]),
      .rd_i    (rdc[i]),
      .data_o  (data[i]),
      .seen_o  (seen[i+1]),
      .first_o (first[i]),
      .rd_o    (rdc[i+1])
    );

    assign first_vec[i] = first[i];
  end

  assign any_match = seen[Capacity];

  always_comb begin
    fidx = '0;
    for (int i = 0; i < Capacity; i++) begin
      if (first_vec[i]) begin
        fidx = fidx | IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q  <= rdc[Capacity];
      found_q       <= found;
      found_index_q <= found ? fidx : '0;
      status_q      <= status;
      length_q      <= cnt_d;
      touched_q     <= touched;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = read_value_q;
  assign found_o       = found_q;
  assign found_index_o = found_index_q;
  assign status_o      = status_q;
  assign length_o      = length_q;
  assign touched_o     = touched_q;

  `OLB_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(Capacity))
  `OLB_ASSERT(a_first_onehot, clk_i, rst_ni, $onehot0(first_vec))
  `OLB_ASSERT(a_ins_grows, clk_i, rst_ni,
    accept && ins |=> cnt_q == CntW'($past(cnt_q) + CntW'(1)))
  `OLB_ASSERT(a_found_in_list, clk_i, rst_ni,
    out_valid_q && found_q |-> CntW'(found_index_q) <= length_q)

endmodule

// ----- hdl/olb_cell.sv -----
module olb_cell
  import olb_pkg::*;
(
  input  logic             clk_i,
  input  olb_cmd_t         cmd_i,
  input  logic [IdxW-1:0]  idx_i,
  input  logic [DataW-1:0] left_i,
  input  logic [DataW-1:0] right_i,
  input  logic             seen_i,
  input  logic [DataW-1:0] rd_i,
  output logic [DataW-1:0] data_o,
  output logic             seen_o,
  output logic             first_o,
  output logic [DataW-1:0] rd_o
);

  logic [DataW-1:0] data_q, data_d;
  logic [PosW-1:0]  my_pos;
  logic             hit, above, below, live, match;

  assign my_pos = PosW'(idx_i);
  assign hit    = (my_pos == cmd_i.pos);
  assign above  = (my_pos > cmd_i.pos);
  assign below  = (my_pos < cmd_i.pos);
  assign live   = (PosW'(idx_i) < PosW'(cmd_i.cnt));
  assign match  = live && (data_q == cmd_i.value);

  // The match flag ripples up the chain so only the lowest match is first.
  assign seen_o  = seen_i | match;
  assign first_o = match & ~seen_i;
  assign rd_o    = rd_i | ((cmd_i.rd_en && hit) ? data_q : '0);

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins_en) begin
      if (above) begin
        data_d = left_i;
      end else if (hit) begin
        data_d = cmd_i.value;
      end
    end else if ((cmd_i.del_en && !below) || (cmd_i.rem_en && seen_o)) begin
      // Removal closes the gap from the matching cell upward.
      data_d = right_i;
    end else if (cmd_i.wr_en && hit) begin
      data_d = cmd_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
